// ===== rtl/mtps_pkg.sv =====
// Package for the max-trace permutation search core.
// Holds sizes, controller/datapath interface structs and permutation helpers.
// Depends on nothing.
package mtps_pkg;

	localparam int MAX_STATES = 8;
	localparam int VALUE_BITS = 16;
	localparam int IDX_W      = $clog2(MAX_STATES);
	localparam int ADDR_W     = 2 * IDX_W;
	localparam int DEPTH      = MAX_STATES * MAX_STATES;
	localparam int SUM_W      = VALUE_BITS + IDX_W;
	localparam int CFG_W      = 4;
	localparam int K_W        = $clog2(MAX_STATES + 1);
	localparam int CFG_RESET  = 4;
	localparam int TRACE_W    = 19;

	typedef logic [MAX_STATES-1:0][IDX_W-1:0] order_t;

	typedef struct packed {
		logic store;
		logic start;
		logic build;
		logic issue;
		logic judge;
		logic emit_next;
		logic finish;
	} mtps_cmd_t;

	typedef struct packed {
		logic last_issue;
		logic last_rank;
		logic emit_last;
	} mtps_status_t;

	function automatic order_t identity_order();
		order_t o;
		for (int i = 0; i < MAX_STATES; i++) begin
			o[i] = IDX_W'(i);
		end
		return o;
	endfunction

	// Digit j has radix j+1; swap position j with position j - digit j.
	function automatic order_t build_order(input order_t dig, input logic [K_W-1:0] k);
		order_t o;
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] t;
		o = identity_order();
		for (int j = 1; j < MAX_STATES; j++) begin
			if (K_W'(j) < k) begin
				a = IDX_W'(j) - dig[j];
				t = o[a];
				o[a] = o[j];
				o[j] = t;
			end
		end
		return o;
	endfunction

endpackage

// ===== rtl/mtps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module mtps_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/mtps_ctrl.sv =====
// Controller state machine for the max-trace permutation search core.
// Depends on mtps_pkg; drives mtps_datapath through command and status structs.
module mtps_ctrl
	import mtps_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic         last_entry,
	output logic         out_valid,
	input  logic         out_ready,
	input  mtps_status_t st,
	output mtps_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_BUILD = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_DRAIN = 3'd3;
	localparam logic [2:0] S_JUDGE = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_EMIT);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.store = 1'b1;
					if (last_entry) begin
						cmd.start = 1'b1;
						state_d   = S_BUILD;
					end
				end
			end
			S_BUILD: begin
				cmd.build = 1'b1;
				state_d   = S_READ;
			end
			S_READ: begin
				cmd.issue = 1'b1;
				if (st.last_issue) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_JUDGE;
			end
			S_JUDGE: begin
				cmd.judge = 1'b1;
				state_d   = st.last_rank ? S_EMIT : S_BUILD;
			end
			S_EMIT: begin
				if (out_ready) begin
					cmd.emit_next = 1'b1;
					if (st.emit_last) begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_read_follows_build: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BUILD |=> state_q == S_READ)
		else $error("read phase did not follow candidate build");
	a_emit_only_after_judge: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.judge) && $past(st.last_rank))
		else $error("emission started without a finished search");
	a_no_load_during_search: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store |-> state_q == S_IDLE)
		else $error("matrix store written outside idle");
`endif

endmodule

// ===== rtl/mtps_datapath.sv =====
// Datapath: matrix store, permutation digits, trace accumulator, best tracking, labels.
// Depends on mtps_pkg and mtps_ram; commanded by mtps_ctrl.
module mtps_datapath
	import mtps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_W-1:0]      cfg_wr_data,
	input  logic                  seq_start,
	input  logic [IDX_W-1:0]      row_index,
	input  logic [IDX_W-1:0]      col_index,
	input  logic [VALUE_BITS-1:0] entry_value,
	input  mtps_cmd_t             cmd,
	output mtps_status_t          st,
	output logic [IDX_W-1:0]      label_position,
	output logic [IDX_W-1:0]      label_value,
	output logic [TRACE_W-1:0]    best_trace,
	output logic                  last_label
);

	logic [CFG_W-1:0]      num_states_q;
	logic [K_W-1:0]        k;
	order_t                dig_q;
	order_t                cand_q;
	order_t                best_ord_q;
	order_t                prev_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      eidx_q;
	logic                  rdv_s1;
	logic                  first_q;
	logic [SUM_W-1:0]      sum_q;
	logic [SUM_W-1:0]      best_q;
	logic [VALUE_BITS-1:0] rd_data;
	logic [IDX_W-1:0]      k_last;
	logic                  all_max;
	order_t                dig_inc;

	always_comb begin
		if (num_states_q < CFG_W'(2)) begin
			k = K_W'(2);
		end else if (num_states_q > CFG_W'(MAX_STATES)) begin
			k = K_W'(MAX_STATES);
		end else begin
			k = K_W'(num_states_q);
		end
	end

	assign k_last = IDX_W'(k - K_W'(1));

	always_comb begin
		logic carry;
		all_max = 1'b1;
		carry   = 1'b1;
		dig_inc = dig_q;
		for (int j = 1; j < MAX_STATES; j++) begin
			if (K_W'(j) < k && dig_q[j] != IDX_W'(j)) begin
				all_max = 1'b0;
			end
			if (carry) begin
				if (dig_q[j] == IDX_W'(j)) begin
					dig_inc[j] = '0;
				end else begin
					dig_inc[j] = dig_q[j] + IDX_W'(1);
					carry      = 1'b0;
				end
			end
		end
	end

	assign st.last_issue = (idx_q == k_last);
	assign st.last_rank  = all_max;
	assign st.emit_last  = (eidx_q == k_last);

	mtps_ram #(
		.WIDTH(VALUE_BITS),
		.DEPTH(DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (cmd.store),
		.wr_addr ({row_index, col_index}),
		.wr_data (entry_value),
		.rd_en   (cmd.issue),
		.rd_addr ({prev_q[idx_q], cand_q[idx_q]}),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_states_q <= CFG_W'(CFG_RESET);
			dig_q        <= '0;
			cand_q       <= identity_order();
			best_ord_q   <= identity_order();
			prev_q       <= identity_order();
			idx_q        <= '0;
			eidx_q       <= '0;
			rdv_s1       <= 1'b0;
			first_q      <= 1'b0;
			sum_q        <= '0;
			best_q       <= '0;
		end else begin
			rdv_s1 <= cmd.issue;
			if (cfg_wr_en) begin
				num_states_q <= cfg_wr_data;
			end
			if (cmd.start) begin
				dig_q      <= '0;
				best_q     <= '0;
				best_ord_q <= identity_order();
				first_q    <= 1'b1;
				eidx_q     <= '0;
				if (seq_start) begin
					prev_q <= identity_order();
				end
			end
			if (cmd.build) begin
				cand_q <= build_order(dig_q, k);
				sum_q  <= '0;
				idx_q  <= '0;
			end else if (rdv_s1) begin
				sum_q <= sum_q + SUM_W'(rd_data);
			end
			if (cmd.issue) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.judge) begin
				first_q <= 1'b0;
				dig_q   <= dig_inc;
				if (first_q || sum_q > best_q) begin
					best_q     <= sum_q;
					best_ord_q <= cand_q;
				end
			end
			if (cmd.emit_next) begin
				eidx_q <= eidx_q + IDX_W'(1);
			end
			if (cmd.finish) begin
				for (int i = 0; i < MAX_STATES; i++) begin
					if (K_W'(i) < k) begin
						prev_q[i] <= best_ord_q[i];
					end
				end
			end
		end
	end

	assign label_position = eidx_q;
	assign label_value    = best_ord_q[eidx_q];
	assign best_trace     = TRACE_W'(best_q);
	assign last_label     = (eidx_q == k_last);

`ifndef NO_ASSERTIONS
	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.judge && !first_q |=> best_q >= $past(best_q))
		else $error("best trace decreased during a search");
	a_start_clears_best: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> best_q == '0 && first_q)
		else $error("search start did not clear the best trace");
	a_reads_within_side: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> K_W'(idx_q) < k)
		else $error("read index beyond matrix side");
`endif

endmodule

// ===== rtl/max_trace_permutation_search_core.sv =====
// Top level of the max-trace permutation search core.
// Depends on mtps_pkg, mtps_ctrl and mtps_datapath.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------------------------
//   in      | in_valid / in_ready  | seq_start row_index col_index entry_value last_entry
//   out     | out_valid/ out_ready | label_position label_value best_trace last_label
//   cfg     | cfg_wr_en            | cfg_wr_data (num_states)
//
// A load transaction without last_entry only writes the matrix store and leaves input open.
// A last_entry transaction starts a search of K! candidates; each is built, read entry
// by entry via the store's single read port and judged; then K output transactions follow.
// New input is refused from search start until the last label is taken.
// Reset is asynchronous; no clearing pass is needed.
module max_trace_permutation_search_core
	import mtps_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_W-1:0]      cfg_wr_data,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  seq_start,
	input  logic [IDX_W-1:0]      row_index,
	input  logic [IDX_W-1:0]      col_index,
	input  logic [VALUE_BITS-1:0] entry_value,
	input  logic                  last_entry,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [IDX_W-1:0]      label_position,
	output logic [IDX_W-1:0]      label_value,
	output logic [TRACE_W-1:0]    best_trace,
	output logic                  last_label
);

	mtps_cmd_t    cmd;
	mtps_status_t st;

	mtps_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.last_entry (last_entry),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.st         (st),
		.cmd        (cmd)
	);

	mtps_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.seq_start      (seq_start),
		.row_index      (row_index),
		.col_index      (col_index),
		.entry_value    (entry_value),
		.cmd            (cmd),
		.st             (st),
		.label_position (label_position),
		.label_value    (label_value),
		.best_trace     (best_trace),
		.last_label     (last_label)
	);

endmodule

// ===== dv/tb_max_trace_permutation_search_core.sv =====
// Testbench for max_trace_permutation_search_core: loads random and directed matrices
// and checks each emitted label against a scoreboard that redoes the search.
// Depends on mtps_pkg and the RTL top level.
module tb_max_trace_permutation_search_core;
	import mtps_pkg::*;

	typedef struct {
		logic [IDX_W-1:0]   pos;
		logic [IDX_W-1:0]   lbl;
		logic [TRACE_W-1:0] trace;
		logic               last;
	} label_t;

	class label_scoreboard;
		logic [VALUE_BITS-1:0] mat [64];
		logic [IDX_W-1:0]      prev [8];
		int                    cfg;
		int                    errors;
		label_t                labels_due [$];

		function new();
			for (int i = 0; i < 64; i++) mat[i] = '0;
			for (int i = 0; i < 8; i++) prev[i] = IDX_W'(i);
			cfg = CFG_RESET;
			errors = 0;
		endfunction

		function int side();
			if (cfg < 2) return 2;
			if (cfg > MAX_STATES) return MAX_STATES;
			return cfg;
		endfunction

		function void note_input(bit seq, int row, int col, logic [VALUE_BITS-1:0] val,
				bit last);
			int fact [9];
			int kk;
			int a;
			logic [IDX_W-1:0] ord [8];
			logic [IDX_W-1:0] best [8];
			logic [IDX_W-1:0] t;
			longint sum;
			longint best_sum;
			label_t lb;
			mat[row * 8 + col] = val;
			if (!last) return;
			fact[0] = 1;
			for (int i = 1; i < 9; i++) fact[i] = fact[i-1] * i;
			kk = side();
			if (seq) for (int i = 0; i < 8; i++) prev[i] = IDX_W'(i);
			best_sum = 0;
			for (int i = 0; i < 8; i++) best[i] = IDX_W'(i);
			for (int r = 0; r < fact[kk]; r++) begin
				for (int i = 0; i < 8; i++) ord[i] = IDX_W'(i);
				for (int i = 2; i <= kk; i++) begin
					a = i - 1 - ((r / fact[i-1]) % i);
					t = ord[a];
					ord[a] = ord[i-1];
					ord[i-1] = t;
				end
				sum = 0;
				for (int i = 0; i < kk; i++) sum += mat[prev[i] * 8 + ord[i]];
				if (r == 0 || sum > best_sum) begin
					best_sum = sum;
					best = ord;
				end
			end
			for (int i = 0; i < kk; i++) begin
				prev[i] = best[i];
				lb.pos = IDX_W'(i);
				lb.lbl = best[i];
				lb.trace = best_sum[TRACE_W-1:0];
				lb.last = (i == kk - 1);
				labels_due.push_back(lb);
			end
		endfunction

		function void check_result(label_t got);
			label_t exp_lb;
			if (labels_due.size() == 0) begin
				$error("label with nothing expected: position %0d", got.pos);
				errors++;
				return;
			end
			exp_lb = labels_due.pop_front();
			if (got.pos !== exp_lb.pos) begin
				$error("label_position expected %0d got %0d", exp_lb.pos, got.pos);
				errors++;
			end
			if (got.lbl !== exp_lb.lbl) begin
				$error("label_value expected %0d got %0d", exp_lb.lbl, got.lbl);
				errors++;
			end
			if (got.trace !== exp_lb.trace) begin
				$error("best_trace expected %0d got %0d", exp_lb.trace, got.trace);
				errors++;
			end
			if (got.last !== exp_lb.last) begin
				$error("last_label expected %0d got %0d", exp_lb.last, got.last);
				errors++;
			end
		endfunction
	endclass

	localparam int LIMIT = 5000000;

	logic                  clk = 0;
	logic                  arst_n = 0;
	logic                  cfg_wr_en = 0;
	logic [CFG_W-1:0]      cfg_wr_data = '0;
	logic                  in_valid = 0;
	logic                  in_ready;
	logic                  seq_start = 0;
	logic [IDX_W-1:0]      row_index = '0;
	logic [IDX_W-1:0]      col_index = '0;
	logic [VALUE_BITS-1:0] entry_value = '0;
	logic                  last_entry = 0;
	logic                  out_valid;
	logic                  out_ready = 0;
	logic [IDX_W-1:0]      label_position;
	logic [IDX_W-1:0]      label_value;
	logic [TRACE_W-1:0]    best_trace;
	logic                  last_label;

	label_scoreboard sb = new();
	int tx_idle = 27;
	int rx_idle = 65;
	int items_sent = 0;
	int cycles = 0;

	max_trace_permutation_search_core u_top (
		.clk(clk), .arst_n(arst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.in_valid(in_valid), .in_ready(in_ready), .seq_start(seq_start),
		.row_index(row_index), .col_index(col_index), .entry_value(entry_value),
		.last_entry(last_entry), .out_valid(out_valid), .out_ready(out_ready),
		.label_position(label_position), .label_value(label_value),
		.best_trace(best_trace), .last_label(last_label)
	);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		label_t got;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_max_trace_permutation_search_core: done, errors");
			$finish;
		end
		if (arst_n && out_valid && out_ready) begin
			got.pos = label_position;
			got.lbl = label_value;
			got.trace = best_trace;
			got.last = last_label;
			sb.check_result(got);
		end
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= rx_idle);
	end

	task automatic send_item(bit seq, int row, int col, logic [VALUE_BITS-1:0] val, bit last);
		while ($urandom_range(99) < tx_idle) begin
			in_valid = 0;
			@(negedge clk);
		end
		seq_start = seq;
		row_index = IDX_W'(row);
		col_index = IDX_W'(col);
		entry_value = val;
		last_entry = last;
		in_valid = 1;
		do @(posedge clk); while (!in_ready);
		sb.note_input(seq, row, col, val, last);
		items_sent++;
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic drain();
		while (sb.labels_due.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_cfg(int value);
		drain();
		cfg_wr_en = 1;
		cfg_wr_data = CFG_W'(value);
		@(negedge clk);
		cfg_wr_en = 0;
		sb.cfg = value;
	endtask

	function automatic logic [VALUE_BITS-1:0] pick_value(int mode);
		case (mode)
			1: return '1;
			2: return '0;
			3: begin
				case ($urandom_range(3))
					0: return '0;
					1: return VALUE_BITS'(1);
					2: return 16'h8000;
					default: return '1;
				endcase
			end
			4: return VALUE_BITS'($urandom_range(3));
			default: return VALUE_BITS'($urandom);
		endcase
	endfunction

	// Every entry that the coming search reads is written, in random order, with
	// stray writes to any index mixed in.
	task automatic load_matrix(bit seq, int mode);
		int kk;
		int rows [8];
		int cells [$];
		int j;
		int t;
		kk = sb.side();
		for (int i = 0; i < kk; i++) rows[i] = seq ? i : sb.prev[i];
		for (int i = 0; i < kk; i++)
			for (int c = 0; c < kk; c++) cells.push_back(rows[i] * 8 + c);
		for (j = cells.size() - 1; j > 0; j--) begin
			t = $urandom_range(j);
			{cells[j], cells[t]} = {cells[t], cells[j]};
		end
		for (j = 0; j < cells.size(); j++) begin
			if ($urandom_range(9) == 0)
				send_item(1'($urandom_range(1)), $urandom_range(7), $urandom_range(7),
					VALUE_BITS'($urandom), 0);
			if (j == cells.size() - 1)
				send_item(seq, cells[j] / 8, cells[j] % 8, pick_value(mode), 1);
			else
				send_item(1'($urandom_range(1)), cells[j] / 8, cells[j] % 8,
					pick_value(mode), 0);
		end
	endtask

	initial begin
		int target;
		repeat (2) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		load_matrix(1, 1);
		load_matrix(0, 2);
		load_matrix(0, 0);
		write_cfg(0);
		load_matrix(0, 3);
		load_matrix(1, 0);
		write_cfg(15);
		load_matrix(0, 0);
		write_cfg(1);
		load_matrix(0, 4);
		write_cfg(5);
		load_matrix(0, 0);

		for (int p = 0; p < 3; p++) begin
			tx_idle = (p == 0) ? 27 : (p == 1) ? 65 : 0;
			rx_idle = (p == 0) ? 65 : (p == 1) ? 27 : 0;
			target = items_sent + 85;
			while (items_sent < target) begin
				if ($urandom_range(9) == 0) write_cfg(7);
				else write_cfg($urandom_range(6));
				repeat ($urandom_range(1, 3))
					load_matrix($urandom_range(4) == 0, $urandom_range(5));
			end
		end

		while (sb.labels_due.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_max_trace_permutation_search_core: done, clean");
		else
			$display("tb_max_trace_permutation_search_core: done, errors");
		$finish;
	end
endmodule
